FILE: rtl/wrvu_pkg.sv
// Shared types, constants and helper functions of the wall repulsion velocity update core.
package wrvu_pkg;

    localparam int MAX_DIMS  = 3;
    localparam int FRAC_BITS = 16;
    localparam int N_LANES   = 2 * MAX_DIMS;   // one lane per wall
    localparam int DIV_STEPS = FRAC_BITS;      // one quotient bit per stage

    // configuration register indexes
    localparam logic [2:0] CFG_DIMS      = 3'd0;
    localparam logic [2:0] CFG_BOX_MIN_X = 3'd1;
    localparam logic [2:0] CFG_BOX_MAX_X = 3'd2;
    localparam logic [2:0] CFG_BOX_MIN_Y = 3'd3;
    localparam logic [2:0] CFG_BOX_MAX_Y = 3'd4;
    localparam logic [2:0] CFG_BOX_MIN_Z = 3'd5;
    localparam logic [2:0] CFG_BOX_MAX_Z = 3'd6;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        agent_radius;
        logic [30:0]        repulsion_gain;
        logic               movable;
        logic               last_agent;
    } t_req;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic               saturated;
        logic               last_out;
    } t_rsp;

    // per-wall divider lane
    typedef struct packed {
        logic                 zero;   // no push from this wall
        logic [30:0]          d;
        logic [30:0]          rem;
        logic [FRAC_BITS-1:0] q;
    } t_lane;

    // item data riding alongside the lanes
    typedef struct packed {
        logic [MAX_DIMS-1:0][31:0] vel;
        logic [30:0]               radius;
        logic [30:0]               gain;
        logic                      mov;
        logic                      last;
    } t_side;

    // one restoring division step
    function automatic t_lane div_step(t_lane l, logic [30:0] rad);
        t_lane      o;
        logic [31:0] rem2;
        logic        ge;
        o    = l;
        rem2 = {l.rem, 1'b0};
        ge   = (rem2 >= {1'b0, rad});
        o.rem = ge ? 31'(rem2 - {1'b0, rad}) : rem2[30:0];
        o.q   = {l.q[FRAC_BITS-2:0], ge};
        return o;
    endfunction

    // clip to signed 32 bits; msb of the result flags a clip
    function automatic logic [32:0] sat32(logic signed [47:0] s);
        logic [32:0] o;
        if (s > 48'sh0000_7FFF_FFFF) begin
            o = {1'b1, 32'h7FFF_FFFF};
        end else if (s < -48'sh0000_8000_0000) begin
            o = {1'b1, 32'h8000_0000};
        end else begin
            o = {1'b0, s[31:0]};
        end
        return o;
    endfunction

endpackage

FILE: rtl/wall_repulsion_velocity_update_core.sv
// Top level of the wall repulsion velocity update core: pipelined datapath and config registers.
//
//  channel   | signals                                   | direction | handshake
//  ----------+-------------------------------------------+-----------+---------------------
//  request   | i_start, o_busy, i_req                    | in        | start & !busy
//  result    | o_valid, o_rsp                            | out       | strobe, one cycle
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index,    | in        | valid & ready
//            | i_cfg_data                                |           |
//
// One request per cycle is taken; o_busy stays low. Each result appears once its request
// has passed one input register, 16 divider stages (one quotient bit each), three
// multiply stages (r^2, *gain, *d) and two saturating add stages.
// Reset (synchronous, active low) clears the valid bits of every stage and sets the
// config registers to three axes and all walls at zero.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module wall_repulsion_velocity_update_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  wrvu_pkg::t_req        i_req,
    output logic                  o_valid,
    output wrvu_pkg::t_rsp        o_rsp,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    import wrvu_pkg::*;

    // config registers
    logic [1:0]                r_dims;
    logic signed [31:0]        r_lo [MAX_DIMS];
    logic signed [31:0]        r_hi [MAX_DIMS];

    // input stage
    logic                      r_iv;
    t_req                      r_in;

    // divider stages
    logic                      r_dv    [DIV_STEPS];
    t_side                     r_dside [DIV_STEPS];
    t_lane                     r_dl    [DIV_STEPS][N_LANES];
    t_lane                     n_dl    [DIV_STEPS][N_LANES];
    t_lane                     n_init  [N_LANES];
    t_side                     n_side;

    // multiply stages
    logic                      r_rv, r_tv, r_mv;
    t_side                     r_rside, r_tside, r_mside;
    logic [FRAC_BITS:0]        r_r2 [N_LANES];
    logic [30:0]               r_rd [N_LANES];
    logic                      r_rz [N_LANES];
    logic [30:0]               r_t  [N_LANES];
    logic [30:0]               r_td [N_LANES];
    logic                      r_tz [N_LANES];
    logic [45:0]               r_m  [N_LANES];

    // add stages
    logic                      r_av;
    t_side                     r_aside;
    logic                      r_asat;
    logic [45:0]               r_amh [MAX_DIMS];
    logic                      r_ov;
    logic                      r_omov;
    t_rsp                      r_rsp;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ov;
    assign o_rsp       = r_rsp;

    // ---------------- config port ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= 2'd3;
            for (int a = 0; a < MAX_DIMS; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIMS:      r_dims   <= i_cfg_data[1:0];
                CFG_BOX_MIN_X: r_lo[0]  <= i_cfg_data;
                CFG_BOX_MAX_X: r_hi[0]  <= i_cfg_data;
                CFG_BOX_MIN_Y: r_lo[1]  <= i_cfg_data;
                CFG_BOX_MAX_Y: r_hi[1]  <= i_cfg_data;
                CFG_BOX_MIN_Z: r_lo[2]  <= i_cfg_data;
                CFG_BOX_MAX_Z: r_hi[2]  <= i_cfg_data;
                default: ;   // unused index, write dropped
            endcase
        end
    end

    // ---------------- distance and lane setup ----------------
    // lane 2a is the min wall of axis a, lane 2a+1 its max wall
    always_comb begin
        logic signed [31:0] pos [MAX_DIMS];
        logic signed [32:0] diff;
        logic [32:0]        d33;
        logic signed [31:0] wall;
        pos[0] = r_in.pos_x;
        pos[1] = r_in.pos_y;
        pos[2] = r_in.pos_z;
        n_side.vel[0] = r_in.vel_x;
        n_side.vel[1] = r_in.vel_y;
        n_side.vel[2] = r_in.vel_z;
        n_side.radius = r_in.agent_radius;
        n_side.gain   = r_in.repulsion_gain;
        n_side.mov    = r_in.movable;
        n_side.last   = r_in.last_agent;
        for (int l = 0; l < N_LANES; l++) begin
            wall = l[0] ? r_hi[l/2] : r_lo[l/2];
            diff = {wall[31], wall} - {pos[l/2][31], pos[l/2]};
            d33  = diff[32] ? 33'(-diff) : 33'(diff);
            if (d33 == '0) begin
                d33 = 33'd1;   // distance floor of one LSB
            end
            n_init[l].zero = !r_in.movable || (32'(l/2) >= {30'd0, r_dims}) ||
                             ({2'b00, r_in.agent_radius} <= d33);
            n_init[l].d    = d33[30:0];
            n_init[l].rem  = d33[30:0];
            n_init[l].q    = '0;
        end
    end

    // ---------------- divider: floor((d << F) / radius) ----------------
    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            n_dl[0][l] = div_step(n_init[l], n_side.radius);
            for (int k = 1; k < DIV_STEPS; k++) begin
                n_dl[k][l] = div_step(r_dl[k-1][l], r_dside[k-1].radius);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_rv <= 1'b0;
            r_tv <= 1'b0;
            r_mv <= 1'b0;
            r_av <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_iv    <= i_start;
            r_dv[0] <= r_iv;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_rv <= r_dv[DIV_STEPS-1];
            r_tv <= r_rv;
            r_mv <= r_tv;
            r_av <= r_mv;
            r_ov <= r_av;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        logic [FRAC_BITS:0]        r;
        logic [2*FRAC_BITS+1:0]    rr;
        logic [47:0]               rg;
        logic [61:0]               td;
        logic [32:0]               s1;
        logic [32:0]               s2;
        logic                      sat;
        logic [MAX_DIMS-1:0][31:0] v;
        t_side                     side;

        r_in       <= i_req;
        r_dside[0] <= n_side;
        for (int k = 1; k < DIV_STEPS; k++) begin
            r_dside[k] <= r_dside[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            for (int l = 0; l < N_LANES; l++) begin
                r_dl[k][l] <= n_dl[k][l];
            end
        end

        // r = 1 - d/radius, then r^2
        r_rside <= r_dside[DIV_STEPS-1];
        for (int l = 0; l < N_LANES; l++) begin
            r  = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, r_dl[DIV_STEPS-1][l].q};
            rr = (2*FRAC_BITS+2)'(r * r);
            r_r2[l] <= rr[2*FRAC_BITS:FRAC_BITS];
            r_rd[l] <= r_dl[DIV_STEPS-1][l].d;
            r_rz[l] <= r_dl[DIV_STEPS-1][l].zero;
        end

        // times gain
        r_tside <= r_rside;
        for (int l = 0; l < N_LANES; l++) begin
            rg = 48'(r_r2[l] * r_rside.gain);
            r_t[l]  <= rg[FRAC_BITS+30:FRAC_BITS];
            r_td[l] <= r_rd[l];
            r_tz[l] <= r_rz[l];
        end

        // times distance
        r_mside <= r_tside;
        for (int l = 0; l < N_LANES; l++) begin
            td = 62'(r_t[l] * r_td[l]);
            r_m[l] <= r_tz[l] ? '0 : td[61:FRAC_BITS];
        end

        // min wall pushes up
        sat = 1'b0;
        v   = r_mside.vel;
        for (int a = 0; a < MAX_DIMS; a++) begin
            s1   = sat32(48'($signed(r_mside.vel[a])) + $signed({2'b00, r_m[2*a]}));
            v[a] = s1[31:0];
            sat  = sat | s1[32];
            r_amh[a] <= r_m[2*a+1];
        end
        side     = r_mside;
        side.vel = v;
        r_aside  <= side;
        r_asat   <= sat;

        // max wall pushes down
        sat = r_asat;
        v   = r_aside.vel;
        for (int a = 0; a < MAX_DIMS; a++) begin
            s2   = sat32(48'($signed(r_aside.vel[a])) - $signed({2'b00, r_amh[a]}));
            v[a] = s2[31:0];
            sat  = sat | s2[32];
        end
        r_rsp.new_vel_x <= v[0];
        r_rsp.new_vel_y <= v[1];
        r_rsp.new_vel_z <= v[2];
        r_rsp.saturated <= sat;
        r_rsp.last_out  <= r_aside.last;
        r_omov          <= r_aside.mov;
    end

    // ---------------- checks ----------------
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv[DIV_STEPS-1] && !r_dl[DIV_STEPS-1][0].zero) |->
        (r_dl[DIV_STEPS-1][0].rem < r_dside[DIV_STEPS-1].radius))
        else $error("divider remainder not below radius");

    a_r2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rv |-> (r_r2[0] <= (FRAC_BITS+1)'(1 << FRAC_BITS)))
        else $error("r squared above one");

    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_av))
        else $error("result strobe without add stage");

    a_immovable_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_omov) |-> !o_rsp.saturated)
        else $error("immovable agent reported saturation");

endmodule
